// File: design/bgr8q_pkg.sv
`default_nettype none

package bgr8q_pkg;

    localparam int MAX_BITS   = 15;
    localparam int SAMPLE_W   = 16;
    localparam int VAL_W      = 16;
    localparam int OUT_W      = 8;
    localparam int CH_N       = 3;
    localparam int DIVIDEND_W = 24;
    // two quotient bits retire per cycle
    localparam int DIV_STEPS  = DIVIDEND_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    // power of two so the pointers wrap on their own
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int IN_DATA_W  = (CH_N + 1) * SAMPLE_W;
    localparam int OUT_DATA_W = CH_N * OUT_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MAX_BITS-1:0]  RESET_MAX  = 15'd1023;
    localparam logic [MAX_BITS-1:0]  PASS_LEVEL = 15'd255;
    localparam logic [OUT_W-1:0]     OUT_FULL   = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_H     = 1'b1;

    typedef struct packed {
        logic [MAX_BITS-1:0] max_value;
        logic                add_h;
    } t_cfg;

    // channel 0 is blue, 1 green, 2 red
    typedef struct packed {
        logic                       first;
        logic [CH_N-1:0][VAL_W-1:0] val;
    } t_item;

    function automatic logic [OUT_W-1:0] sat8(input logic [DIVIDEND_W-1:0] q);
        logic [OUT_W-1:0] r;
        if (q > DIVIDEND_W'(OUT_FULL)) begin
            r = OUT_FULL;
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/bgr8q_front.sv
`default_nettype none

module bgr8q_front import bgr8q_pkg::*; (
    input  wire t_cfg                            i_cfg,
    input  wire logic                            i_valid,
    input  wire logic                            i_first,
    input  wire logic [CH_N-1:0][SAMPLE_W-1:0]   i_samples,
    input  wire logic [SAMPLE_W-1:0]             i_h,
    input  wire logic                            i_full,
    output logic                                 o_ready,
    output logic                                 o_push,
    output t_item                                o_item
);

    logic signed [SAMPLE_W:0] h_ext;

    assign h_ext   = i_cfg.add_h ? $signed({i_h[SAMPLE_W-1], i_h}) : '0;
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        logic signed [SAMPLE_W:0] s;
        o_item.first = i_first;
        for (int c = 0; c < CH_N; c++) begin
            s = $signed({i_samples[c][SAMPLE_W-1], i_samples[c]}) + h_ext;
            // negative sums clamp to zero
            o_item.val[c] = s[SAMPLE_W] ? '0 : VAL_W'(s[SAMPLE_W-1:0]);
        end
    end

endmodule

`default_nettype wire

// File: design/bgr8q_fifo.sv
`default_nettype none

module bgr8q_fifo import bgr8q_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    input  wire logic  i_pop,
    output t_item      o_data,
    output logic       o_full,
    output logic       o_empty
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr;
    logic [FIFO_AW-1:0]    r_rd;
    logic [FIFO_CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/bgr8q_div.sv
`default_nettype none

// Restoring divider, two quotient bits per step. Quotient bits shift in
// behind the dividend bits as they are consumed.
module bgr8q_div import bgr8q_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic                  i_step,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [MAX_BITS-1:0]   i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quot,
    output logic      [MAX_BITS-1:0]   o_rem
);

    logic [DIVIDEND_W-1:0] r_work;
    logic [MAX_BITS-1:0]   r_rem;
    logic [DIVIDEND_W-1:0] n_work;
    logic [MAX_BITS-1:0]   n_rem;

    assign o_quot = r_work;
    assign o_rem  = r_rem;

    always_comb begin
        logic [MAX_BITS:0]   t;
        logic [MAX_BITS-1:0] r;
        logic [1:0]          qb;
        r = r_rem;
        for (int k = 0; k < 2; k++) begin
            t = {r, r_work[DIVIDEND_W-1-k]};
            qb[1-k] = (t >= {1'b0, i_divisor});
            if (qb[1-k]) begin
                t = t - {1'b0, i_divisor};
            end
            r = t[MAX_BITS-1:0];
        end
        n_rem  = r;
        n_work = {r_work[DIVIDEND_W-3:0], qb};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (i_step) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

endmodule

`default_nettype wire

// File: design/bgr8q_back.sv
`default_nettype none

module bgr8q_back import bgr8q_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_empty,
    input  wire t_item                  i_item,
    output logic                        o_pop,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_DATA_W-1:0]       o_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [STEP_W-1:0]               r_step;
    logic [CH_N-1:0][MAX_BITS-1:0]   r_carry;
    logic [CH_N-1:0][VAL_W-1:0]      r_val;
    logic                            r_out_valid;
    logic [CH_N-1:0][OUT_W-1:0]      r_out_data;

    logic [MAX_BITS-1:0]             half_max;
    logic                            div_used;
    logic                            take;
    logic [CH_N-1:0][MAX_BITS-1:0]   carry_eff;
    logic [CH_N-1:0][DIVIDEND_W-1:0] dividend;
    logic [CH_N-1:0][DIVIDEND_W-1:0] quot;
    logic [CH_N-1:0][MAX_BITS-1:0]   rem;
    logic [CH_N-1:0][OUT_W-1:0]      res;

    assign half_max = i_cfg.max_value >> 1;
    assign div_used = (i_cfg.max_value != PASS_LEVEL) && (i_cfg.max_value != '0);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign take     = (r_state == S_DONE) && (!r_out_valid || i_tready);
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            carry_eff[c] = i_item.first ? half_max : r_carry[c];
            // v*255 + carry
            dividend[c]  = {i_item.val[c], 8'd0} - {8'd0, i_item.val[c]}
                         + {{(DIVIDEND_W-MAX_BITS){1'b0}}, carry_eff[c]};
            if (i_cfg.max_value == PASS_LEVEL) begin
                res[c] = sat8({{(DIVIDEND_W-VAL_W){1'b0}}, r_val[c]});
            end else if (i_cfg.max_value == '0) begin
                res[c] = OUT_FULL;
            end else begin
                res[c] = sat8(quot[c]);
            end
        end
    end

    for (genvar c = 0; c < CH_N; c++) begin : g_lane
        bgr8q_div u_div (
            .i_clk      (i_clk),
            .i_load     (o_pop),
            .i_step     (r_state == S_DIV),
            .i_dividend (dividend[c]),
            .i_divisor  (i_cfg.max_value),
            .o_quot     (quot[c]),
            .o_rem      (rem[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CH_N; c++) begin
                r_carry[c] <= RESET_MAX >> 1;
            end
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_val   <= i_item.val;
                        r_carry <= carry_eff;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (take) begin
                        r_out_data  <= res;
                        if (div_used) begin
                            r_carry <= rem;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/bgrh_to_bgr8_error_carry_requantize_core.sv
`default_nettype none

// Requantizes one pixel of signed B, G, R samples (with an optional shared H
// offset) to 8-bit BGR, carrying each channel's division remainder on to the
// next pixel. A front stage adds H and clamps at zero, a two-item queue
// decouples it from the back end, and the back end runs three 24/15-bit
// dividers in parallel at two quotient bits a cycle. The back end handles one
// pixel at a time, in order: load, 12 divide steps, hand-off to the output
// register. The output register lets the next pixel start while a result
// waits. Set tuser to 1 on the first pixel of an image to reset the carries
// to max_value/2. Write the registers only while the block is empty.
module bgrh_to_bgr8_error_carry_requantize_core import bgr8q_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [MAX_BITS-1:0]    i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,   // in_b, in_g, in_r, in_h
    input  wire logic [0:0]             s_axis_tuser,   // first_of_image
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata    // out_b, out_g, out_r
);

    t_cfg  r_cfg;
    t_item push_item;
    t_item head_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_value <= RESET_MAX;
            r_cfg.add_h     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_VALUE: r_cfg.max_value <= i_cfg_wdata;
                CFG_ADD_H:     r_cfg.add_h     <= i_cfg_wdata[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    bgr8q_front u_front (
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .i_first   (s_axis_tuser[0]),
        .i_samples (s_axis_tdata[CH_N*SAMPLE_W-1:0]),
        .i_h       (s_axis_tdata[IN_DATA_W-1:CH_N*SAMPLE_W]),
        .i_full    (full),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_item    (push_item)
    );

    bgr8q_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    bgr8q_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_item   (head_item),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
